FILE: rtl/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Types and constants shared by the fixed pool slot allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

	localparam int SLOTS_DEF = 64;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [5:0] slot;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] granted_slot;
		logic [6:0] live_count;
		logic [6:0] high_water;
	} rsp_t;

endpackage

FILE: rtl/fpsa_first_free.sv
// ----------------------------------------------------------------------------
// fpsa_first_free
// Finds the lowest-numbered clear bit of the busy map.
// ----------------------------------------------------------------------------
module fpsa_first_free #(
	parameter int SLOTS = fpsa_pkg::SLOTS_DEF,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic [SLOTS-1:0] busy_map,
	output logic             any_free,
	output logic [IW-1:0]    idx
);
	import fpsa_pkg::*;

	logic [SLOTS-1:0] lowest;

	// isolate lowest zero bit as a one-hot vector
	assign lowest   = ~busy_map & (busy_map + SLOTS'(1));
	assign any_free = |lowest;

	always_comb begin
		idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (lowest[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

FILE: rtl/fixed_pool_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_pool_slot_allocator_unit
// Bitmap first-fit slot allocator: allocate grants the lowest free slot,
// free releases a named slot; live count and high-water mark are tracked.
// ----------------------------------------------------------------------------
// The request is registered in valid_s1/req_s1, and its response is then
// registered in rsp_q when the response register is empty or being taken.
// One request per cycle unless rsp_ready stalls; map and counts update at
// the response register's edge, so the next request sees them at once.
// Reset: asynchronous, clears the busy map, both counts and all valid flags.
module fixed_pool_slot_allocator_unit #(
	parameter int SLOTS = fpsa_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fpsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fpsa_pkg::rsp_t rsp
);
	import fpsa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic             valid_s1;
	req_t             req_s1;
	logic [SLOTS-1:0] map_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    peak_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             advance;
	logic             any_free;
	logic [IW-1:0]    free_idx;
	logic             slot_busy;
	logic             ok;
	logic [SLOTS-1:0] map_d;
	logic [CW-1:0]    cnt_d;
	logic [CW-1:0]    peak_d;
	logic [5:0]       grant;

	fpsa_first_free #(.SLOTS(SLOTS)) u_first_free (
		.busy_map (map_q),
		.any_free (any_free),
		.idx      (free_idx)
	);

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign slot_busy = (32'(req_s1.slot) < SLOTS) && map_q[IW'(req_s1.slot)];

	always_comb begin
		map_d  = map_q;
		cnt_d  = cnt_q;
		peak_d = peak_q;
		ok     = 1'b0;
		grant  = '0;
		unique case (req_s1.opcode)
			OP_ALLOC: begin
				if (any_free) begin
					map_d[free_idx] = 1'b1;
					cnt_d = cnt_q + CW'(1);
					ok    = 1'b1;
					grant = 6'(free_idx);
					if (cnt_d > peak_q) begin
						peak_d = cnt_d;
					end
				end
			end
			OP_FREE: begin
				if (slot_busy) begin
					map_d[IW'(req_s1.slot)] = 1'b0;
					cnt_d = cnt_q - CW'(1);
					ok    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			map_q       <= '0;
			cnt_q       <= '0;
			peak_q      <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				map_q       <= map_d;
				cnt_q       <= cnt_d;
				peak_q      <= peak_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q.ok           <= ok;
			rsp_q.granted_slot <= grant;
			rsp_q.live_count   <= 7'(cnt_d);
			rsp_q.high_water   <= 7'(peak_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(map_q))
		else $error("live count differs from busy map population");

	a_peak_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= cnt_q && 32'(peak_q) <= SLOTS)
		else $error("high-water mark out of bounds");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.ok |-> rsp_q.granted_slot == 6'd0)
		else $error("failed request carries a granted slot");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(map_q) && $stable(cnt_q) && $stable(peak_q))
		else $error("state changed without a request");
`endif

endmodule

FILE: bench/fixed_pool_slot_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// fixed_pool_slot_allocator_unit_tb
// Self-checking bench for the bitmap slot allocator. A directed table covers
// reset values, pool full, double free and the slot extremes; random bursts
// then fill and drain the pool. Responses are checked against pinned table
// values or a model of the busy map and counts; both channels stall randomly.
// ----------------------------------------------------------------------------
module fixed_pool_slot_allocator_unit_tb;
	import fpsa_pkg::*;

	localparam int POOL        = SLOTS_DEF;
	localparam int RAND_ITEMS  = 1900;
	localparam int IDLE_PCT    = 22;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic       op;
		logic [5:0] slot;
		int         reps;
		bit         pinned;
		rsp_t       pin;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	bit   want_pin;
	rsp_t pin_rsp;
	bit   steady_run = 1'b0;

	logic [POOL-1:0] pool_busy = '0;
	logic [6:0]      live_cnt  = '0;
	logic [6:0]      peak_cnt  = '0;
	rsp_t            grants_due[$];
	int              err_cnt = 0;
	int              stall_cycles = 0;

	dir_row_t dir_rows [0:15] = '{
		'{OP_ALLOC, 6'd0,  1,  1'b1, '{1'b1, 6'd0,  7'd1,  7'd1}},
		'{OP_FREE,  6'd63, 1,  1'b1, '{1'b0, 6'd0,  7'd1,  7'd1}},
		'{OP_FREE,  6'd0,  1,  1'b1, '{1'b1, 6'd0,  7'd0,  7'd1}},
		'{OP_FREE,  6'd0,  1,  1'b1, '{1'b0, 6'd0,  7'd0,  7'd1}},
		'{OP_ALLOC, 6'd0,  64, 1'b0, '0},
		'{OP_ALLOC, 6'd0,  1,  1'b1, '{1'b0, 6'd0,  7'd64, 7'd64}},
		'{OP_FREE,  6'd63, 1,  1'b1, '{1'b1, 6'd0,  7'd63, 7'd64}},
		'{OP_ALLOC, 6'd0,  1,  1'b1, '{1'b1, 6'd63, 7'd64, 7'd64}},
		'{OP_FREE,  6'd0,  1,  1'b1, '{1'b1, 6'd0,  7'd63, 7'd64}},
		'{OP_FREE,  6'd21, 1,  1'b0, '0},
		'{OP_FREE,  6'd42, 1,  1'b0, '0},
		'{OP_ALLOC, 6'd0,  1,  1'b1, '{1'b1, 6'd0,  7'd62, 7'd64}},
		'{OP_ALLOC, 6'd0,  1,  1'b1, '{1'b1, 6'd21, 7'd63, 7'd64}},
		'{OP_ALLOC, 6'd0,  1,  1'b0, '0},
		'{OP_FREE,  6'd5,  1,  1'b1, '{1'b1, 6'd0,  7'd63, 7'd64}},
		'{OP_FREE,  6'd5,  1,  1'b1, '{1'b0, 6'd0,  7'd63, 7'd64}}
	};

	fixed_pool_slot_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t grant_model(input req_t r);
		rsp_t o;
		int   idx;
		o   = '0;
		idx = -1;
		if (r.opcode == OP_ALLOC) begin
			for (int i = POOL - 1; i >= 0; i--)
				if (!pool_busy[i]) idx = i;
			if (idx >= 0) begin
				pool_busy[idx] = 1'b1;
				live_cnt = live_cnt + 7'd1;
				if (live_cnt > peak_cnt) peak_cnt = live_cnt;
				o.ok           = 1'b1;
				o.granted_slot = idx[5:0];
			end
		end else if (int'(r.slot) < POOL && pool_busy[r.slot]) begin
			pool_busy[r.slot] = 1'b0;
			if (live_cnt > 0) live_cnt = live_cnt - 7'd1;
			o.ok = 1'b1;
		end
		o.live_count = live_cnt;
		o.high_water = peak_cnt;
		return o;
	endfunction

	// slot with the given busy state, scanned from a random start
	function automatic logic [5:0] pick_slot(input bit busy);
		int start;
		start = $urandom_range(0, POOL - 1);
		for (int i = 0; i < POOL; i++)
			if (pool_busy[(start + i) % POOL] == busy) return 6'((start + i) % POOL);
		return 6'(start);
	endfunction

	task automatic check_field(input string what, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t predicted;
		rsp_t want;
		if (arst_n && req_valid && req_ready) begin
			predicted = grant_model(req);
			grants_due.push_back(want_pin ? pin_rsp : predicted);
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (grants_due.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual %h", $time, rsp);
				err_cnt++;
			end else begin
				want = grants_due.pop_front();
				check_field("ok", want.ok, rsp.ok);
				check_field("granted_slot", want.granted_slot, rsp.granted_slot);
				check_field("live_count", want.live_count, rsp.live_count);
				check_field("high_water", want.high_water, rsp.high_water);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);

	// called and returns at a falling edge
	task automatic send_req(input logic op, input logic [5:0] slot, input bit pinned,
			input rsp_t pin);
		req_t item;
		item.opcode = op;
		item.slot   = slot;
		while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		want_pin  <= pinned;
		pin_rsp   <= pin;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_all_granted();
		req_valid <= 1'b0;
		@(negedge clk);
		while (grants_due.size() != 0) @(negedge clk);
	endtask

	initial begin
		int   rand_sent;
		int   mode;
		int   burst;
		bit   paused;
		logic op;
		logic [5:0] slot;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		want_pin  = 1'b0;
		pin_rsp   = '0;
		rand_sent = 0;
		paused    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r])
			for (int k = 0; k < dir_rows[r].reps; k++)
				send_req(dir_rows[r].op, dir_rows[r].slot, dir_rows[r].pinned, dir_rows[r].pin);

		wait_all_granted();

		while (rand_sent < RAND_ITEMS) begin
			if (!paused && rand_sent >= 1200) begin
				wait_all_granted();
				paused = 1'b1;
			end
			steady_run = (rand_sent >= 700 && rand_sent < 1000);
			mode = $urandom_range(0, 99);
			burst = (mode < 70) ? $urandom_range(1, 80) : $urandom_range(1, 20);
			for (int k = 0; k < burst; k++) begin
				if (mode < 35) begin
					// fill: mostly allocate
					op   = ($urandom_range(0, 9) == 0) ? OP_FREE : OP_ALLOC;
					slot = (op == OP_FREE) ? pick_slot(1'b1) : 6'($urandom);
				end else if (mode < 70) begin
					// drain: mostly free busy slots
					op   = ($urandom_range(0, 9) == 0) ? OP_ALLOC : OP_FREE;
					slot = (op == OP_FREE) ? pick_slot(1'b1) : 6'($urandom);
				end else if (mode < 85) begin
					op   = 1'($urandom);
					slot = 6'($urandom);
				end else begin
					// double free
					op   = OP_FREE;
					slot = pick_slot(1'b0);
				end
				send_req(op, slot, 1'b0, '0);
				rand_sent++;
			end
		end
		steady_run = 1'b0;

		req_valid <= 1'b0;
		@(negedge clk);
		while (grants_due.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
